// ----- design/delayed_event_task_scheduler_defines.svh -----
// assertion macros for the delayed event task scheduler checker
`ifndef DELAYED_EVENT_TASK_SCHEDULER_DEFINES_SVH
`define DELAYED_EVENT_TASK_SCHEDULER_DEFINES_SVH
// assert an implication, reported by label
`define DETS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// assert an implication checked in the next cycle
`define DETS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`endif

// ----- design/dets_pkg.sv -----
// shared types and constants for the delayed event task scheduler
package dets_pkg;
   localparam int TASKS = 8;
   localparam int EVENT_SLOTS = 16;
   localparam int SLOT_W = $clog2(EVENT_SLOTS);
   localparam int TASK_W = 3;
   localparam int CNT_W = $clog2(EVENT_SLOTS + 1);

   localparam logic [2:0] CMD_SEND = 3'd0;
   localparam logic [2:0] CMD_CLEAR = 3'd1;
   localparam logic [2:0] CMD_TICK = 3'd2;
   localparam logic [2:0] CMD_DISPATCH = 3'd3;
   localparam logic [2:0] CMD_REQUEUE = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_BITS = 2'd1;
   localparam logic [1:0] ST_BAD_TASK = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic CSR_TASK_COUNT = 1'b0;
   localparam logic CSR_IDLE_EN = 1'b1;

   typedef struct packed {
      logic [2:0] command;
      logic [2:0] task_number;
      logic [31:0] event_bits;
      logic [31:0] delay_ticks;
      logic periodic;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic ready_found;
      logic [2:0] ready_task;
      logic [31:0] handed_events;
      logic idle;
      logic [4:0] pending_delayed;
      logic [31:0] tick_total;
   } rsp_type;

   typedef struct packed {
      logic used;
      logic [TASK_W-1:0] task_id;
      logic [31:0] bits;
      logic [31:0] countdown;
      logic [31:0] reload;
   } slot_type;
endpackage

// ----- design/dets_slot_table.sv -----
// delayed event slot table: one slot read and written per cycle by index
module dets_slot_table (
   input  logic clock,
   input  logic reset,
   input  logic [dets_pkg::SLOT_W-1:0] rd_index,
   output dets_pkg::slot_type rd_slot,
   input  logic wr_en,
   input  logic [dets_pkg::SLOT_W-1:0] wr_index,
   input  dets_pkg::slot_type wr_slot
);
   dets_pkg::slot_type slots_ff [dets_pkg::EVENT_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dets_pkg::EVENT_SLOTS; i++) slots_ff[i].used <= 1'b0;
      end else if (wr_en) begin
         slots_ff[wr_index] <= wr_slot;
      end
   end

   assign rd_slot = slots_ff[rd_index];
endmodule

// ----- design/delayed_event_task_scheduler.sv -----
// top level of the delayed event task scheduler
// usage:
//  req_ channel carries one command per transfer (send, clear, tick, dispatch,
//  requeue); rsp_ channel returns exactly one result per command.
//  csr_ channel writes task_count (index 0) and idle_enabled (index 1), always ready.
// command flow:
//  every command walks the whole slot table one slot a cycle, then a done step
//  and an output step; rsp_valid is registered in the output step.
//  the next command is taken the cycle after the result transfer.
//  a single slot read/write port makes the walk go slot by slot.
//  req_stall is high while a command is in progress or a result waits.
// reset:
//  synchronous, clears state, rsp_valid, csr fields, pending flags, in-use bits, counters.
// stall:
//  a result held by rsp_stall stays on rsp_data; no new command is taken
//  until it is transferred.
module delayed_event_task_scheduler (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  dets_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output dets_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [3:0] csr_data
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DONE = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   dets_pkg::req_type cmd_ff;
   logic [3:0] task_count_ff;
   logic idle_en_ff;
   logic [31:0] pending_ff [dets_pkg::TASKS];
   logic [dets_pkg::CNT_W-1:0] used_ff;
   logic [dets_pkg::TASK_W-1:0] running_ff;
   logic [31:0] ticks_ff;
   logic [dets_pkg::CNT_W-1:0] idx_ff;
   // scan memory: first matching slot and first free slot
   logic match_ok_ff, free_ok_ff;
   logic [dets_pkg::SLOT_W-1:0] match_ff, free_ff;
   dets_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;

   dets_pkg::slot_type rd_slot, wr_slot;
   logic wr_en;
   logic [dets_pkg::SLOT_W-1:0] wr_index, rd_index;
   logic [dets_pkg::SLOT_W-1:0] idx_lo;
   logic [dets_pkg::TASK_W-1:0] cmd_task;
   logic task_ok;
   logic args_ok;
   logic [31:0] dec;
   logic hit;

   assign idx_lo = idx_ff[dets_pkg::SLOT_W-1:0];
   // the done step reads back the matched slot
   assign rd_index = (state_ff == S_DONE) ? match_ff : idx_lo;
   assign cmd_task = cmd_ff.task_number;
   // valid task when below min(task_count, TASKS)
   assign task_ok = ({1'b0, task_count_ff} > {2'b0, cmd_task});
   // send and clear go ahead only with flags and a valid task
   assign args_ok = (cmd_ff.event_bits != 32'd0) && task_ok;
   assign dec = rd_slot.countdown - 32'd1;
   assign hit = rd_slot.used && rd_slot.task_id == cmd_task && rd_slot.bits == cmd_ff.event_bits;

   dets_slot_table u_slots (
      .clock(clock), .reset(reset), .rd_index(rd_index), .rd_slot(rd_slot),
      .wr_en(wr_en), .wr_index(wr_index), .wr_slot(wr_slot)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // tick writes each used slot under scan; a delayed send and a matching clear write in the done step
   always_comb begin
      wr_en = 1'b0;
      wr_index = idx_lo;
      wr_slot = rd_slot;
      if (state_ff == S_SCAN && cmd_ff.command == dets_pkg::CMD_TICK && rd_slot.used) begin
         wr_en = 1'b1;
         if (dec == 32'd0) begin
            if (rd_slot.reload == 32'd0) wr_slot.used = 1'b0;
            else wr_slot.countdown = rd_slot.reload;
         end else begin
            wr_slot.countdown = dec;
         end
      end else if (state_ff == S_DONE && cmd_ff.command == dets_pkg::CMD_SEND && args_ok &&
                   cmd_ff.delay_ticks != 32'd0) begin
         if (match_ok_ff) begin
            wr_en = 1'b1;
            wr_index = match_ff;
            wr_slot = rd_slot;
            wr_slot.countdown = cmd_ff.delay_ticks;
         end else if (free_ok_ff) begin
            wr_en = 1'b1;
            wr_index = free_ff;
            wr_slot.used = 1'b1;
            wr_slot.task_id = cmd_task;
            wr_slot.bits = cmd_ff.event_bits;
            wr_slot.countdown = cmd_ff.delay_ticks;
            wr_slot.reload = cmd_ff.periodic ? cmd_ff.delay_ticks : 32'd0;
         end
      end else if (state_ff == S_DONE && cmd_ff.command == dets_pkg::CMD_CLEAR && args_ok &&
                   match_ok_ff) begin
         wr_en = 1'b1;
         wr_index = match_ff;
         wr_slot.used = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid && !req_stall) state_in = S_SCAN;
         S_SCAN: if (idx_ff == dets_pkg::CNT_W'(dets_pkg::EVENT_SLOTS - 1)) state_in = S_DONE;
         S_DONE: state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         task_count_ff <= 4'd0;
         idle_en_ff <= 1'b0;
         for (int t = 0; t < dets_pkg::TASKS; t++) pending_ff[t] <= 32'd0;
         used_ff <= '0;
         running_ff <= '0;
         ticks_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            if (csr_index == dets_pkg::CSR_TASK_COUNT) task_count_ff <= csr_data;
            else idle_en_ff <= csr_data[0];
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  cmd_ff <= req_data;
                  idx_ff <= '0;
                  match_ok_ff <= 1'b0;
                  free_ok_ff <= 1'b0;
                  if (req_data.command == dets_pkg::CMD_TICK) ticks_ff <= ticks_ff + 32'd1;
               end
            end
            S_SCAN: begin
               idx_ff <= idx_ff + 1'b1;
               if (hit && !match_ok_ff) begin
                  match_ok_ff <= 1'b1;
                  match_ff <= idx_lo;
               end
               if (!rd_slot.used && !free_ok_ff) begin
                  free_ok_ff <= 1'b1;
                  free_ff <= idx_lo;
               end
               if (cmd_ff.command == dets_pkg::CMD_TICK && rd_slot.used && dec == 32'd0) begin
                  pending_ff[rd_slot.task_id] <= pending_ff[rd_slot.task_id] | rd_slot.bits;
                  if (rd_slot.reload == 32'd0 && used_ff != '0) used_ff <= used_ff - 1'b1;
               end
            end
            S_DONE: begin : done_step
               dets_pkg::rsp_type r;
               logic fnd;
               r = '0;
               fnd = 1'b0;
               case (cmd_ff.command)
                  dets_pkg::CMD_SEND, dets_pkg::CMD_CLEAR: begin
                     if (cmd_ff.event_bits == 32'd0) r.status = dets_pkg::ST_NO_BITS;
                     else if (!task_ok) r.status = dets_pkg::ST_BAD_TASK;
                     else if (cmd_ff.command == dets_pkg::CMD_CLEAR) begin
                        pending_ff[cmd_task] <= pending_ff[cmd_task] & ~cmd_ff.event_bits;
                        if (match_ok_ff && used_ff != '0) used_ff <= used_ff - 1'b1;
                     end else if (cmd_ff.delay_ticks == 32'd0) begin
                        pending_ff[cmd_task] <= pending_ff[cmd_task] | cmd_ff.event_bits;
                     end else if (!match_ok_ff) begin
                        if (free_ok_ff) used_ff <= used_ff + 1'b1;
                        else r.status = dets_pkg::ST_FULL;
                     end
                  end
                  dets_pkg::CMD_DISPATCH: begin
                     for (int t = 0; t < dets_pkg::TASKS; t++) begin
                        if (!fnd && {1'b0, task_count_ff} > 5'(t) && pending_ff[t] != 32'd0) begin
                           fnd = 1'b1;
                           r.ready_found = 1'b1;
                           r.ready_task = 3'(t);
                           r.handed_events = pending_ff[t];
                           pending_ff[t] <= 32'd0;
                           running_ff <= dets_pkg::TASK_W'(t);
                        end
                     end
                     if (!fnd && idle_en_ff && used_ff == '0) r.idle = 1'b1;
                  end
                  dets_pkg::CMD_REQUEUE:
                     pending_ff[running_ff] <= pending_ff[running_ff] | cmd_ff.event_bits;
                  default: ;
               endcase
               rsp_ff <= r;
            end
            S_OUT: begin
               // counters are final here, so the result is registered for output
               rsp_valid_ff <= 1'b1;
               rsp_ff.pending_delayed <= 5'(used_ff);
               rsp_ff.tick_total <= ticks_ff;
            end
            default: ;
         endcase
      end
   end
endmodule

// ----- design/dets_checker.sv -----
// port-level checker for the delayed event task scheduler, bound to the top level
`include "delayed_event_task_scheduler_defines.svh"
module dets_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input dets_pkg::rsp_type rsp_data
);
   `DETS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `DETS_ASSERT_IMP(a_stall_with_rsp, clock, reset, rsp_valid, req_stall)
   `DETS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   `DETS_ASSERT_IMP(a_pend_range, clock, reset, rsp_valid, rsp_data.pending_delayed <= 5'd16)
endmodule

bind delayed_event_task_scheduler dets_checker u_dets_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
